// ===== rtl/tile_grid_nearby_wall_query_unit_assert.svh =====
// Assertion macros shared by the tile grid query RTL.
`ifndef TILE_GRID_NEARBY_WALL_QUERY_UNIT_ASSERT_SVH
`define TILE_GRID_NEARBY_WALL_QUERY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TGNW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgnw assertion failed");
`define TGNW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgnw assertion failed");
`define TGNW_ASSERT_NEXT2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("tgnw assertion failed");
`else
`define TGNW_ASSERT_NOW(label, ante, cons)
`define TGNW_ASSERT_NEXT(label, ante, cons)
`define TGNW_ASSERT_NEXT2(label, ante, cons)
`endif
`endif

// ===== rtl/tgnw_pkg.sv =====
// Shared types and constants of the tile grid query unit.
package tgnw_pkg;

  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = 5;
  localparam int EXT_W     = 12;

  localparam logic [1:0] ACT_GET   = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_EXTENT  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/tgnw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tgnw_div
  import tgnw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [EXT_W-1:0] divisor,
  output div_rsp_t         rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [EXT_W:0]       rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [EXT_W:0]       shifted;
  logic                 ge;
  logic [EXT_W:0]       rem_nxt;

  assign shifted = {rem_r[EXT_W-1:0], quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign rem_nxt = ge ? (shifted - {1'b0, divisor}) : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/tgnw_grid.sv =====
// One-bit tile store with one write port and one registered read port.
module tgnw_grid #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tile_grid_nearby_wall_query_unit.sv =====
// Get: the tile is read in the GET state and its word is registered in GET_OUT; set: the tile
// is written in the SET state. Query: four floor divisions on one shared 21-step divider, a
// window state, a scan of the n window tiles (at most WINDOW_MAX squared) one tile per cycle,
// then the drain and finish states (finish alone if the window is empty); the final word is
// out in the same cycle as busy falls. Words leave at most one a cycle and the receiver cannot
// stall. After reset busy stays high while the grid is cleared; config writes are always taken.
`include "tile_grid_nearby_wall_query_unit_assert.svh"
module tile_grid_nearby_wall_query_unit
  import tgnw_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int WINDOW_MAX  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [20:0] in_pos_x,
  input  logic signed [20:0] in_pos_y,
  input  logic [19:0]        in_box_width,
  input  logic [19:0]        in_box_height,
  input  logic               in_new_tile,
  output logic               out_valid,
  output logic               out_tile_read,
  output logic               out_wall_found,
  output logic [5:0]         out_wall_column,
  output logic [5:0]         out_wall_row,
  output logic [17:0]        out_wall_left,
  output logic [17:0]        out_wall_top,
  output logic               out_last
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_CLEAR     = 11'b000_0000_0010,
    ST_GET       = 11'b000_0000_0100,
    ST_GET_OUT   = 11'b000_0000_1000,
    ST_SET       = 11'b000_0001_0000,
    ST_DIV_START = 11'b000_0010_0000,
    ST_DIV_WAIT  = 11'b000_0100_0000,
    ST_WINDOW    = 11'b000_1000_0000,
    ST_SCAN      = 11'b001_0000_0000,
    ST_DRAIN     = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]  map_columns_r;
  logic [6:0]  map_rows_r;
  logic [11:0] tile_extent_r;
  logic [11:0] t_eff;

  logic signed [20:0] px_r, py_r;
  logic [19:0]        bw_r, bh_r;
  logic               nt_r;

  logic [AW-1:0] clr_addr_r;
  logic [1:0]    div_idx_r;
  logic signed [23:0] q_r [4];

  logic [CW-1:0] c_r, c0_r, c1_r;
  logic [RW-1:0] r_r, r1_r;
  logic          rd_vld_r;
  logic [CW-1:0] rd_c_r;
  logic [RW-1:0] rd_r_r;
  logic          pend_vld_r;
  logic [CW-1:0] pend_c_r;
  logic [RW-1:0] pend_r_r;
  logic          get_in_r;

  logic          accept;
  logic signed [23:0] cols_s, rows_s;
  logic          get_in;
  logic [AW-1:0] get_addr, scan_addr;
  logic signed [21:0] sum_x, sum_y, sel_a, mag;
  logic          neg;
  logic signed [23:0] q_signed;
  logic signed [23:0] lo_c, hi_c, lo_r, hi_r;
  logic          win_empty;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic          out_valid_r, out_valid_nxt;
  logic          out_tile_read_r, out_tile_read_nxt;
  logic          out_wall_found_r, out_wall_found_nxt;
  logic [5:0]    out_wall_column_r, out_wall_column_nxt;
  logic [5:0]    out_wall_row_r, out_wall_row_nxt;
  logic [17:0]   out_wall_left_r, out_wall_left_nxt;
  logic [17:0]   out_wall_top_r, out_wall_top_nxt;
  logic          out_last_r, out_last_nxt;
  logic [CW+11:0] left_full;
  logic [RW+11:0] top_full;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign t_eff  = (tile_extent_r == 12'd0) ? 12'd1 : tile_extent_r;

  assign cols_s = (24'(map_columns_r) > 24'(MAX_COLUMNS)) ? 24'(MAX_COLUMNS)
                                                           : 24'(map_columns_r);
  assign rows_s = (24'(map_rows_r) > 24'(MAX_ROWS)) ? 24'(MAX_ROWS) : 24'(map_rows_r);

  assign get_in = !px_r[20] && !py_r[20] && (24'(px_r) < cols_s) && (24'(py_r) < rows_s);
  assign get_addr  = AW'(py_r[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(px_r[CW-1:0]);
  assign scan_addr = AW'(r_r) * AW'(MAX_COLUMNS) + AW'(c_r);

  assign sum_x = 22'(px_r) + $signed({2'b00, bw_r});
  assign sum_y = 22'(py_r) + $signed({2'b00, bh_r});

  always_comb begin
    case (div_idx_r)
      2'd0:    sel_a = 22'(px_r);
      2'd1:    sel_a = sum_x;
      2'd2:    sel_a = 22'(py_r);
      default: sel_a = sum_y;
    endcase
  end

  assign neg      = sel_a[21];
  assign mag      = neg ? ~sel_a : sel_a;
  assign q_signed = neg ? ~{3'b000, div_rsp.quotient} : {3'b000, div_rsp.quotient};

  assign div_req.start    = (state_r == ST_DIV_START);
  assign div_req.dividend = mag[DIV_W-1:0];

  tgnw_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (t_eff),
    .rsp     (div_rsp)
  );

  always_comb begin
    lo_c = q_r[0] - 24'sd1;
    if (lo_c < 0) lo_c = '0;
    hi_c = q_r[1] + 24'sd1;
    if (hi_c > cols_s - 24'sd1) hi_c = cols_s - 24'sd1;
    if (hi_c > lo_c + 24'(WINDOW_MAX - 1)) hi_c = lo_c + 24'(WINDOW_MAX - 1);
    lo_r = q_r[2] - 24'sd1;
    if (lo_r < 0) lo_r = '0;
    hi_r = q_r[3] + 24'sd1;
    if (hi_r > rows_s - 24'sd1) hi_r = rows_s - 24'sd1;
    if (hi_r > lo_r + 24'(WINDOW_MAX - 1)) hi_r = lo_r + 24'(WINDOW_MAX - 1);
    win_empty = (hi_c < lo_c) || (hi_r < lo_r);
  end

  assign mem_we    = (state_r == ST_CLEAR) || ((state_r == ST_SET) && get_in);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : get_addr;
  assign mem_wdata = (state_r == ST_CLEAR) ? 1'b0 : nt_r;
  assign mem_raddr = (state_r == ST_SCAN) ? scan_addr : get_addr;

  tgnw_grid #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_GET:   state_nxt = ST_GET;
            ACT_SET:   state_nxt = ST_SET;
            ACT_QUERY: state_nxt = ST_DIV_START;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:     if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_GET:       state_nxt = ST_GET_OUT;
      ST_GET_OUT:   state_nxt = ST_IDLE;
      ST_SET:       state_nxt = ST_IDLE;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (div_idx_r == 2'd3) ? ST_WINDOW : ST_DIV_START;
        end
      end
      ST_WINDOW:    state_nxt = win_empty ? ST_FINISH : ST_SCAN;
      ST_SCAN:      if ((c_r == c1_r) && (r_r == r1_r)) state_nxt = ST_DRAIN;
      ST_DRAIN:     state_nxt = ST_FINISH;
      ST_FINISH:    state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      map_columns_r <= 7'd64;
      map_rows_r    <= 7'd64;
      tile_extent_r <= 12'd256;
      rd_vld_r      <= 1'b0;
      pend_vld_r    <= 1'b0;
      div_idx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: map_columns_r <= cfg_wdata[6:0];
          REG_ROWS:    map_rows_r    <= cfg_wdata[6:0];
          REG_EXTENT:  tile_extent_r <= cfg_wdata;
          default:     ;
        endcase
      end
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (accept) begin
        div_idx_r  <= '0;
        pend_vld_r <= 1'b0;
      end
      if ((state_r == ST_DIV_WAIT) && div_rsp.done) div_idx_r <= div_idx_r + 1'b1;
      rd_vld_r <= (state_r == ST_SCAN);
      if (rd_vld_r && mem_rdata) pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      bw_r  <= in_box_width;
      bh_r  <= in_box_height;
      nt_r  <= in_new_tile;
    end
    if (state_r == ST_GET) get_in_r <= get_in;
    if ((state_r == ST_DIV_WAIT) && div_rsp.done) q_r[div_idx_r] <= q_signed;
    if (state_r == ST_WINDOW) begin
      c0_r <= CW'(lo_c);
      c1_r <= CW'(hi_c);
      r1_r <= RW'(hi_r);
      c_r  <= CW'(lo_c);
      r_r  <= RW'(lo_r);
    end
    if (state_r == ST_SCAN) begin
      rd_c_r <= c_r;
      rd_r_r <= r_r;
      if (c_r == c1_r) begin
        c_r <= c0_r;
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    if (rd_vld_r && mem_rdata) begin
      pend_c_r <= rd_c_r;
      pend_r_r <= rd_r_r;
    end
  end

  assign left_full = (CW+12)'(pend_c_r) * (CW+12)'(t_eff);
  assign top_full  = (RW+12)'(pend_r_r) * (RW+12)'(t_eff);

  always_comb begin
    out_valid_nxt       = 1'b0;
    out_tile_read_nxt   = 1'b0;
    out_wall_found_nxt  = 1'b0;
    out_wall_column_nxt = '0;
    out_wall_row_nxt    = '0;
    out_wall_left_nxt   = '0;
    out_wall_top_nxt    = '0;
    out_last_nxt        = 1'b0;
    if (state_r == ST_GET_OUT) begin
      out_valid_nxt     = 1'b1;
      out_tile_read_nxt = get_in_r ? mem_rdata : 1'b1;
      out_last_nxt      = 1'b1;
    end else if ((rd_vld_r && mem_rdata && pend_vld_r) ||
                 ((state_r == ST_FINISH) && pend_vld_r)) begin
      out_valid_nxt       = 1'b1;
      out_wall_found_nxt  = 1'b1;
      out_wall_column_nxt = 6'(pend_c_r);
      out_wall_row_nxt    = 6'(pend_r_r);
      out_wall_left_nxt   = 18'(left_full);
      out_wall_top_nxt    = 18'(top_full);
      out_last_nxt        = (state_r == ST_FINISH);
    end else if (state_r == ST_FINISH) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tile_read_r   <= out_tile_read_nxt;
    out_wall_found_r  <= out_wall_found_nxt;
    out_wall_column_r <= out_wall_column_nxt;
    out_wall_row_r    <= out_wall_row_nxt;
    out_wall_left_r   <= out_wall_left_nxt;
    out_wall_top_r    <= out_wall_top_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tile_read   = out_tile_read_r;
  assign out_wall_found  = out_wall_found_r;
  assign out_wall_column = out_wall_column_r;
  assign out_wall_row    = out_wall_row_r;
  assign out_wall_left   = out_wall_left_r;
  assign out_wall_top    = out_wall_top_r;
  assign out_last        = out_last_r;

  `TGNW_ASSERT_NEXT2(a_get_gives_word, (state_r == ST_GET), out_valid_r && out_last_r)
  `TGNW_ASSERT_NEXT(a_finish_ends_item, (state_r == ST_FINISH), out_valid_r && out_last_r)
  `TGNW_ASSERT_NOW(a_more_words_follow, out_valid_r && !out_last_r, state_r != ST_IDLE)
  `TGNW_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_r == ST_DIV_WAIT)

endmodule
